// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
// Needs nothing else; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequent must hold whenever the antecedent holds, on the same edge.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold a fixed number of edges after the antecedent.
`define ASSERT_DELAY(label, clk, rst, ante, n, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

// ===== hdl/sbgra_pkg.sv =====
// Shared constants, types and helper functions of the scaled BGRA converter.
// Used by the scaling lanes, the color lanes and the top level; needs nothing else.
package sbgra_pkg;

  localparam int MAX_DIM = 4096;
  localparam int COORD_W = $clog2(MAX_DIM);
  localparam int DIM_W = COORD_W + 1;
  localparam int PROD_W = 2 * DIM_W;
  // One divide stage per quotient bit; the product stage comes in front of them.
  localparam int PIPE_DEPTH = COORD_W;

  localparam logic OP_MAP = 1'b0;
  localparam logic OP_CONVERT = 1'b1;

  localparam logic [1:0] FMT_BGRA = 2'd0;
  localparam logic [1:0] FMT_ARGB = 2'd1;
  localparam logic [1:0] FMT_UYVY = 2'd2;

  localparam logic [2:0] REG_PIXEL_FORMAT = 3'd0;
  localparam logic [2:0] REG_MIRROR = 3'd1;
  localparam logic [2:0] REG_SRC_WIDTH = 3'd2;
  localparam logic [2:0] REG_SRC_HEIGHT = 3'd3;
  localparam logic [2:0] REG_DST_WIDTH = 3'd4;
  localparam logic [2:0] REG_DST_HEIGHT = 3'd5;

  // BT.601 studio-range coefficients, magnitudes only; signs are in the lane.
  localparam logic [16:0] C_YR = 17'd66;
  localparam logic [16:0] C_YG = 17'd129;
  localparam logic [16:0] C_YB = 17'd25;
  localparam logic [16:0] C_UR = 17'd38;
  localparam logic [16:0] C_UG = 17'd74;
  localparam logic [16:0] C_UB = 17'd112;
  localparam logic [16:0] C_VR = 17'd112;
  localparam logic [16:0] C_VG = 17'd94;
  localparam logic [16:0] C_VB = 17'd18;
  localparam logic [16:0] ROUND_HALF = 17'd128;
  localparam logic [16:0] CHROMA_BIAS = 17'd32896;
  localparam logic [7:0] LUMA_OFFSET = 8'd16;

  typedef struct packed {
    logic [DIM_W-1:0] src;
    logic [DIM_W-1:0] dst;
  } dim_pair_t;

  typedef struct packed {
    logic [7:0] y;
    logic [7:0] u;
    logic [7:0] v;
  } yuv_t;

  // A size of zero counts as one, a size above the maximum as the maximum.
  function automatic logic [DIM_W-1:0] eff_size(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
    return r;
  endfunction

endpackage

// ===== hdl/sbgra_scale_lane.sv =====
// One nearest-neighbour scaling lane: floor(coord*src/dst) clamped to src-1.
// Uses sbgra_pkg; a multiply stage followed by one restoring-divide stage per bit.
module sbgra_scale_lane (
  input  logic                          clk,
  input  logic [sbgra_pkg::DIM_W-1:0]   coord,
  input  sbgra_pkg::dim_pair_t          dims,
  output logic [sbgra_pkg::COORD_W-1:0] result
);

  localparam int NS = sbgra_pkg::PIPE_DEPTH;

  logic [sbgra_pkg::PROD_W-1:0]  rem [0:NS];
  logic [sbgra_pkg::COORD_W-1:0] quo [0:NS];
  logic [sbgra_pkg::DIM_W-1:0]   div [0:NS];
  logic [sbgra_pkg::COORD_W-1:0] lim [0:NS];
  logic                          ovr [0:NS];
  logic [sbgra_pkg::DIM_W-1:0]   s_eff;
  logic [sbgra_pkg::DIM_W-1:0]   t_eff;

  assign s_eff = sbgra_pkg::eff_size(dims.src);
  assign t_eff = sbgra_pkg::eff_size(dims.dst);

  // When coord >= dst the quotient reaches src, so the clamp wins and the
  // divider may run on garbage; otherwise the quotient fits COORD_W bits.
  always_ff @(posedge clk) begin
    rem[0] <= sbgra_pkg::PROD_W'(coord) * sbgra_pkg::PROD_W'(s_eff);
    quo[0] <= '0;
    div[0] <= t_eff;
    lim[0] <= sbgra_pkg::COORD_W'(s_eff - sbgra_pkg::DIM_W'(1));
    ovr[0] <= (coord >= t_eff);
  end

  for (genvar k = 1; k <= NS; k++) begin : g_div
    localparam int B = NS - k;
    logic [sbgra_pkg::PROD_W-1:0]  trial;
    logic                          fits;
    logic [sbgra_pkg::COORD_W-1:0] quo_next;

    assign trial = sbgra_pkg::PROD_W'(div[k-1]) << B;
    assign fits = (rem[k-1] >= trial);
    // Bit B is still clear here, since only this stage decides it.
    assign quo_next = quo[k-1] | (sbgra_pkg::COORD_W'(fits) << B);

    always_ff @(posedge clk) begin
      rem[k] <= fits ? rem[k-1] - trial : rem[k-1];
      quo[k] <= quo_next;
      div[k] <= div[k-1];
      lim[k] <= lim[k-1];
      ovr[k] <= ovr[k-1];
    end
  end

  assign result = ovr[NS] ? lim[NS] : quo[NS];

endmodule

// ===== hdl/sbgra_color_lane.sv =====
// One color lane: BT.601 studio-range Y, U and V of a single pixel, registered.
// Uses sbgra_pkg for coefficients; U and V come out before the pair averaging.
module sbgra_color_lane (
  input  logic            clk,
  input  logic [7:0]      red,
  input  logic [7:0]      green,
  input  logic [7:0]      blue,
  output sbgra_pkg::yuv_t yuv
);

  logic [16:0] y_sum;
  logic [16:0] u_sum;
  logic [16:0] v_sum;

  // With the bias added the chroma sums are always positive, at most 16 bits,
  // and every result already lies inside 0..255.
  always_comb begin
    y_sum = 17'(red) * sbgra_pkg::C_YR + 17'(green) * sbgra_pkg::C_YG
          + 17'(blue) * sbgra_pkg::C_YB + sbgra_pkg::ROUND_HALF;
    u_sum = 17'(blue) * sbgra_pkg::C_UB + sbgra_pkg::CHROMA_BIAS
          - (17'(red) * sbgra_pkg::C_UR + 17'(green) * sbgra_pkg::C_UG);
    v_sum = 17'(red) * sbgra_pkg::C_VR + sbgra_pkg::CHROMA_BIAS
          - (17'(green) * sbgra_pkg::C_VG + 17'(blue) * sbgra_pkg::C_VB);
  end

  always_ff @(posedge clk) begin
    yuv.y <= y_sum[15:8] + sbgra_pkg::LUMA_OFFSET;
    yuv.u <= u_sum[15:8];
    yuv.v <= v_sum[15:8];
  end

endmodule

// ===== hdl/scaled_bgra_pixel_format_converter.sv =====
// Top level of the scaled BGRA converter: registers, lanes, merge and output.
// Uses sbgra_pkg, sbgra_scale_lane and sbgra_color_lane.
//
//   channel   handshake                 payload
//   input     start / busy              op, dest_x, dest_y, first_*, second_*
//   result    done (one-cycle strobe)   src_col_*, src_row, pixel_data, word_count
//   config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One word is accepted every clock; busy stays low.
// Each result leaves the output registers behind the multiply stage and the 12-stage
// column and row dividers; convert words take the same path length.
// Reset clears the pipeline valid bits and loads the register defaults.
// The receiver cannot stall, so nothing ever holds back the pipeline.
module scaled_bgra_pixel_format_converter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          op,
  input  logic [11:0]                   dest_x,
  input  logic [11:0]                   dest_y,
  input  logic [7:0]                    first_blue,
  input  logic [7:0]                    first_green,
  input  logic [7:0]                    first_red,
  input  logic [7:0]                    first_alpha,
  input  logic [7:0]                    second_blue,
  input  logic [7:0]                    second_green,
  input  logic [7:0]                    second_red,
  input  logic [7:0]                    second_alpha,
  output logic                          done,
  output logic [11:0]                   src_col_first,
  output logic [11:0]                   src_col_second,
  output logic [11:0]                   src_row,
  output logic [63:0]                   pixel_data,
  output logic [1:0]                    word_count,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [2:0]                    cfg_index,
  input  logic [12:0]                   cfg_data
);

  localparam int NS = sbgra_pkg::PIPE_DEPTH;

  logic [1:0]                  pixel_format;
  logic                        mirror;
  logic [sbgra_pkg::DIM_W-1:0] src_width;
  logic [sbgra_pkg::DIM_W-1:0] src_height;
  logic [sbgra_pkg::DIM_W-1:0] dst_width;
  logic [sbgra_pkg::DIM_W-1:0] dst_height;

  logic                        accept;
  logic [NS:0]                 vld;
  logic [NS:0]                 opc;
  logic [63:0]                 cdata [1:NS];
  logic [1:0]                  cwords [1:NS];

  sbgra_pkg::dim_pair_t        dims_x;
  sbgra_pkg::dim_pair_t        dims_y;
  logic [sbgra_pkg::DIM_W-1:0] x0;
  logic [sbgra_pkg::DIM_W-1:0] x1;
  logic [sbgra_pkg::DIM_W-1:0] y0;
  logic [11:0]                 col0;
  logic [11:0]                 col1;
  logic [11:0]                 row;
  logic [11:0]                 col_top;

  logic [7:0]                  b0, g0, r0, a0, b1, g1, r1, a1;
  sbgra_pkg::yuv_t             yuv0;
  sbgra_pkg::yuv_t             yuv1;
  logic [8:0]                  u_pair;
  logic [8:0]                  v_pair;
  logic [63:0]                 merged;
  logic [1:0]                  merged_words;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= sbgra_pkg::FMT_UYVY;
      mirror <= 1'b0;
      src_width <= 13'd1920;
      src_height <= 13'd1080;
      dst_width <= 13'd1920;
      dst_height <= 13'd1080;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sbgra_pkg::REG_PIXEL_FORMAT: pixel_format <= cfg_data[1:0];
        sbgra_pkg::REG_MIRROR:       mirror <= cfg_data[0];
        sbgra_pkg::REG_SRC_WIDTH:    src_width <= cfg_data;
        sbgra_pkg::REG_SRC_HEIGHT:   src_height <= cfg_data;
        sbgra_pkg::REG_DST_WIDTH:    dst_width <= cfg_data;
        sbgra_pkg::REG_DST_HEIGHT:   dst_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Three scaling lanes: the column, the next column and the row.
  assign dims_x = '{src: src_width, dst: dst_width};
  assign dims_y = '{src: src_height, dst: dst_height};
  assign x0 = sbgra_pkg::DIM_W'(dest_x);
  assign x1 = sbgra_pkg::DIM_W'(dest_x) + sbgra_pkg::DIM_W'(1);
  assign y0 = sbgra_pkg::DIM_W'(dest_y);

  sbgra_scale_lane u_lane_col0 (.clk(clk), .coord(x0), .dims(dims_x), .result(col0));
  sbgra_scale_lane u_lane_col1 (.clk(clk), .coord(x1), .dims(dims_x), .result(col1));
  sbgra_scale_lane u_lane_row  (.clk(clk), .coord(y0), .dims(dims_y), .result(row));

  // Two color lanes, one per pixel of the pair.
  sbgra_color_lane u_lane_pix0 (
    .clk(clk), .red(first_red), .green(first_green), .blue(first_blue), .yuv(yuv0)
  );
  sbgra_color_lane u_lane_pix1 (
    .clk(clk), .red(second_red), .green(second_green), .blue(second_blue), .yuv(yuv1)
  );

  always_ff @(posedge clk) begin
    b0 <= first_blue;
    g0 <= first_green;
    r0 <= first_red;
    a0 <= first_alpha;
    b1 <= second_blue;
    g1 <= second_green;
    r1 <= second_red;
    a1 <= second_alpha;
  end

  // Merge stage: average the chroma of the pair and pack the chosen format.
  always_comb begin
    u_pair = (9'(yuv0.u) + 9'(yuv1.u)) >> 1;
    v_pair = (9'(yuv0.v) + 9'(yuv1.v)) >> 1;
    case (pixel_format)
      sbgra_pkg::FMT_ARGB: begin
        merged = {b1, g1, r1, a1, b0, g0, r0, a0};
        merged_words = 2'd2;
      end
      sbgra_pkg::FMT_UYVY: begin
        merged = {32'd0, yuv1.y, v_pair[7:0], yuv0.y, u_pair[7:0]};
        merged_words = 2'd1;
      end
      default: begin
        merged = {a1, r1, g1, b1, a0, r0, g0, b0};
        merged_words = 2'd2;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[NS-1:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    opc <= {opc[NS-1:0], op};
    cdata[1] <= merged;
    cwords[1] <= merged_words;
  end

  for (genvar i = 2; i <= NS; i++) begin : g_delay
    always_ff @(posedge clk) begin
      cdata[i] <= cdata[i-1];
      cwords[i] <= cwords[i-1];
    end
  end

  assign col_top = 12'(sbgra_pkg::eff_size(src_width) - sbgra_pkg::DIM_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (opc[NS] == sbgra_pkg::OP_MAP) begin
      src_col_first <= mirror ? col_top - col0 : col0;
      src_col_second <= mirror ? col_top - col1 : col1;
      src_row <= row;
      pixel_data <= '0;
      word_count <= 2'd0;
    end else begin
      src_col_first <= '0;
      src_col_second <= '0;
      src_row <= '0;
      pixel_data <= cdata[NS];
      word_count <= cwords[NS];
    end
  end

endmodule

// ===== hdl/sbgra_checker.sv =====
// Port-level checker for the scaled BGRA converter, attached by bind.
// Needs assert_macros.svh; sees only the ports of the top level.
`include "assert_macros.svh"

module sbgra_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [11:0] src_col_first,
  input logic [11:0] src_col_second,
  input logic [11:0] src_row,
  input logic [63:0] pixel_data,
  input logic [1:0]  word_count
);

  `ASSERT_ALWAYS(a_never_busy, clk, rst, !busy, "busy was raised")
  `ASSERT_DELAY(a_latency, clk, rst, start && !busy, 14, done,
    "result missing after a word")
  `ASSERT_IMPLY(a_convert_clear, clk, rst, done && word_count != 2'd0,
    src_col_first == 12'd0 && src_col_second == 12'd0 && src_row == 12'd0,
    "coordinates set on a convert result")
  `ASSERT_IMPLY(a_map_clear, clk, rst, done && word_count == 2'd0,
    pixel_data == 64'd0, "pixel data set on a map result")
  `ASSERT_IMPLY(a_uyvy_upper, clk, rst, done && word_count == 2'd1,
    pixel_data[63:32] == 32'd0, "upper word set on a UYVY result")

endmodule

bind scaled_bgra_pixel_format_converter sbgra_checker u_sbgra_checker (
  .clk(clk),
  .rst(rst),
  .start(start),
  .busy(busy),
  .done(done),
  .src_col_first(src_col_first),
  .src_col_second(src_col_second),
  .src_row(src_row),
  .pixel_data(pixel_data),
  .word_count(word_count)
);
